FILE: src/cfru_pkg.sv
// package for the clock frame replacement unit
// types, action and status codes, default sizes; no dependencies
package cfru_pkg;

    localparam int FRAMES_DEF    = 256;
    localparam int PAGE_BITS_DEF = 23;
    localparam int SLOT_BITS_DEF = 19;

    localparam int IDX_W   = 9;
    localparam int LIMIT_W = 9;
    localparam int ACT_W   = 3;
    localparam int STAT_W  = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 9'd256;

    localparam logic [ACT_W-1:0] ACT_REQUEST = 3'd0;
    localparam logic [ACT_W-1:0] ACT_UNPIN   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DIRTY   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PIN     = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_MODIFY,
        S_PUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch request, clear result
        logic fresh;      // claim the next unused frame
        logic full;       // report every frame pinned
        logic bad;        // report index out of range
        logic hand_rd;    // advance hand, read entry under it
        logic idx_rd;     // read entry at frame index
        logic chance_set; // give entry under hand its second chance
        logic evict;      // replace entry under hand
        logic modify;     // apply unpin, dirty, release or pin
        logic put;        // move result into output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_req;
        logic is_unknown;
        logic fresh_ok;
        logic all_pinned;
        logic idx_bad;
        logic ent_pinned;
        logic ent_chance;
    } t_stat;

endpackage

FILE: src/cfru_ctrl.sv
// controller state machine for the clock frame replacement unit
// depends on cfru_pkg
module cfru_ctrl import cfru_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    input  logic  i_m_ready,
    input  t_stat i_stat,
    output logic  o_s_ready,
    output logic  o_m_valid,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   w_out_free;

    assign w_out_free = !r_m_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.is_req) begin
                    if (i_stat.fresh_ok || i_stat.all_pinned) n_state = S_PUT;
                    else n_state = S_WALK;
                end else if (i_stat.is_unknown || i_stat.idx_bad) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_MODIFY;
                end
            end
            S_WALK: begin
                if (!i_stat.ent_pinned && i_stat.ent_chance) n_state = S_PUT;
            end
            S_MODIFY: n_state = S_PUT;
            S_PUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        n_m_valid = r_m_valid && !i_m_ready;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                o_cmd.load = i_s_valid;
            end
            S_DECIDE: begin
                if (i_stat.is_req) begin
                    if (i_stat.fresh_ok) o_cmd.fresh = 1'b1;
                    else if (i_stat.all_pinned) o_cmd.full = 1'b1;
                    else o_cmd.hand_rd = 1'b1;
                end else if (!i_stat.is_unknown) begin
                    if (i_stat.idx_bad) o_cmd.bad = 1'b1;
                    else o_cmd.idx_rd = 1'b1;
                end
            end
            S_WALK: begin
                if (i_stat.ent_pinned) begin
                    o_cmd.hand_rd = 1'b1;
                end else if (!i_stat.ent_chance) begin
                    o_cmd.chance_set = 1'b1;
                    o_cmd.hand_rd    = 1'b1;
                end else begin
                    o_cmd.evict = 1'b1;
                end
            end
            S_MODIFY: o_cmd.modify = 1'b1;
            S_PUT: begin
                if (w_out_free) begin
                    o_cmd.put = 1'b1;
                    n_m_valid = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_m_valid = r_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

endmodule

FILE: src/cfru_dp.sv
// datapath for the clock frame replacement unit: frame table memory,
// clock hand, counters, result and output registers; depends on cfru_pkg
module cfru_dp import cfru_pkg::*; #(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int SLOT_BITS = SLOT_BITS_DEF,
    localparam int IN_W  = ((IDX_W + PAGE_BITS + 2 * SLOT_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((IDX_W + PAGE_BITS + SLOT_BITS + 3 + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,
    input  logic [ACT_W-1:0]   i_act,
    input  logic [IN_W-1:0]    i_data,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic [OUT_W-1:0]   o_data,
    output logic [STAT_W-1:0]  o_status
);

    localparam int AW = $clog2(FRAMES);
    localparam int CW = AW + 1;
    localparam int W  = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int EW = 3 + PAGE_BITS + SLOT_BITS;
    localparam int RAW_W = IDX_W + PAGE_BITS + SLOT_BITS + 3;
    // entry layout
    localparam int E_PIN   = 0;
    localparam int E_CHN   = 1;
    localparam int E_DRT   = 2;
    localparam int E_OWN   = 3;
    localparam int E_SLT   = 3 + PAGE_BITS;

    logic [EW-1:0] mem [FRAMES];
    logic [EW-1:0] r_rd;

    logic [LIMIT_W-1:0]   r_limit;
    logic [CW-1:0]        r_n;
    logic [CW-1:0]        r_pc;
    logic [AW-1:0]        r_hand;

    logic [ACT_W-1:0]     r_act;
    logic [IDX_W-1:0]     r_idx;
    logic [PAGE_BITS-1:0] r_page;
    logic [SLOT_BITS-1:0] r_inslot;
    logic [SLOT_BITS-1:0] r_spare;

    logic [IDX_W-1:0]     r_granted;
    logic                 r_evicted;
    logic [PAGE_BITS-1:0] r_vpage;
    logic                 r_wout;
    logic [SLOT_BITS-1:0] r_vslot;
    logic                 r_spare_tk;
    logic [STAT_W-1:0]    r_status;

    logic [OUT_W-1:0]     r_out;
    logic [STAT_W-1:0]    r_out_st;

    logic [W-1:0]   w_limit_x, w_cap_x, w_n_x, w_idx_x, w_idx_m1;
    logic [AW-1:0]  w_idx_k, w_hand_nx, w_ra, w_wa;
    logic [CW-1:0]  w_hand_p1;
    logic [EW-1:0]  w_claim, w_mod, w_wd;
    logic           w_we, w_re;
    logic           w_ent_dirty;
    logic [SLOT_BITS-1:0] w_ent_slot;
    logic [RAW_W-1:0]     w_raw;

    // sizes
    assign w_limit_x = W'(r_limit);
    assign w_cap_x   = (w_limit_x < W'(FRAMES)) ? w_limit_x : W'(FRAMES);
    assign w_n_x     = W'(r_n);
    assign w_idx_x   = W'(r_idx);
    assign w_idx_m1  = w_idx_x - W'(1);
    assign w_idx_k   = w_idx_m1[AW-1:0];

    // hand wraps at the number of frames handed out
    assign w_hand_p1 = {1'b0, r_hand} + CW'(1);
    assign w_hand_nx = (w_hand_p1 == r_n) ? '0 : w_hand_p1[AW-1:0];

    assign o_stat.is_req     = (r_act == ACT_REQUEST);
    assign o_stat.is_unknown = (r_act > ACT_PIN);
    assign o_stat.fresh_ok   = (w_n_x < w_cap_x);
    assign o_stat.all_pinned = (r_pc == r_n);
    assign o_stat.idx_bad    = (r_idx == '0) || (w_idx_x > w_n_x);
    assign o_stat.ent_pinned = r_rd[E_PIN];
    assign o_stat.ent_chance = r_rd[E_CHN];

    assign w_ent_dirty = r_rd[E_DRT];
    assign w_ent_slot  = r_rd[E_SLT +: SLOT_BITS];

    // pinned, chance unused, clean, new owner and slot
    always_comb begin
        w_claim = '0;
        w_claim[E_PIN] = 1'b1;
        w_claim[E_OWN +: PAGE_BITS] = r_page;
        w_claim[E_SLT +: SLOT_BITS] = r_inslot;
    end

    always_comb begin
        w_mod = r_rd;
        unique case (r_act)
            ACT_UNPIN: w_mod[E_PIN] = 1'b0;
            ACT_DIRTY: begin
                w_mod[E_DRT] = 1'b1;
                w_mod[E_CHN] = 1'b0;
            end
            ACT_RELEASE: begin
                w_mod = '0;
                w_mod[E_CHN] = 1'b1;
            end
            ACT_PIN: w_mod[E_PIN] = 1'b1;
            default: w_mod = r_rd;
        endcase
    end

    always_comb begin
        w_we = i_cmd.fresh || i_cmd.chance_set || i_cmd.evict || i_cmd.modify;
        w_wa = r_hand;
        w_wd = w_claim;
        if (i_cmd.fresh) begin
            w_wa = r_n[AW-1:0];
        end else if (i_cmd.chance_set) begin
            w_wd = r_rd;
            w_wd[E_CHN] = 1'b1;
        end else if (i_cmd.modify) begin
            w_wa = w_idx_k;
            w_wd = w_mod;
        end
    end

    assign w_re = i_cmd.hand_rd || i_cmd.idx_rd;
    assign w_ra = i_cmd.hand_rd ? w_hand_nx : w_idx_k;

    // frame table, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_wa] <= w_wd;
        if (w_re) begin
            if (w_we && (w_wa == w_ra)) r_rd <= w_wd;
            else r_rd <= mem[w_ra];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
            r_n     <= '0;
            r_pc    <= '0;
            r_hand  <= '0;
        end else begin
            if (i_cfg_wr_en) r_limit <= i_cfg_wr_data;
            if (i_cmd.fresh) r_n <= r_n + CW'(1);
            if (i_cmd.hand_rd) r_hand <= w_hand_nx;
            if (i_cmd.fresh || i_cmd.evict) begin
                r_pc <= r_pc + CW'(1);
            end else if (i_cmd.modify) begin
                if ((r_act == ACT_UNPIN || r_act == ACT_RELEASE) && r_rd[E_PIN])
                    r_pc <= r_pc - CW'(1);
                else if (r_act == ACT_PIN && !r_rd[E_PIN])
                    r_pc <= r_pc + CW'(1);
            end
        end
    end

    // request latch and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act      <= i_act;
            r_idx      <= i_data[IDX_W-1:0];
            r_page     <= i_data[IDX_W +: PAGE_BITS];
            r_inslot   <= i_data[IDX_W + PAGE_BITS +: SLOT_BITS];
            r_spare    <= i_data[IDX_W + PAGE_BITS + SLOT_BITS +: SLOT_BITS];
            r_granted  <= '0;
            r_evicted  <= 1'b0;
            r_vpage    <= '0;
            r_wout     <= 1'b0;
            r_vslot    <= '0;
            r_spare_tk <= 1'b0;
            r_status   <= ST_OK;
        end
        if (i_cmd.fresh) r_granted <= IDX_W'(r_n + CW'(1));
        if (i_cmd.full)  r_status  <= ST_FULL;
        if (i_cmd.bad)   r_status  <= ST_BAD;
        if (i_cmd.evict) begin
            r_granted <= IDX_W'(w_hand_p1);
            r_evicted <= 1'b1;
            r_vpage   <= r_rd[E_OWN +: PAGE_BITS];
            r_wout    <= w_ent_dirty;
            if (w_ent_dirty && (w_ent_slot == '0)) begin
                r_vslot    <= r_spare;
                r_spare_tk <= 1'b1;
            end else begin
                r_vslot    <= w_ent_slot;
            end
        end
    end

    assign w_raw = {r_spare_tk, r_vslot, r_wout, r_vpage, r_evicted, r_granted};

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_out    <= OUT_W'(w_raw);
            r_out_st <= r_status;
        end
    end

    assign o_data   = r_out;
    assign o_status = r_out_st;

endmodule

FILE: src/clock_frame_replacement_unit.sv
// top level of the clock frame replacement unit
// depends on cfru_pkg, cfru_ctrl, cfru_dp
//
// channel   direction  signals                       contents
// s_*       in         s_tvalid s_tready s_tdata     one request per item
//                      s_tuser                       action code
// m_*       out        m_tvalid m_tready m_tdata     one result per request
//                      m_tuser                       status code
// cfg       in         i_cfg_wr_en i_cfg_wr_data     frame_limit register
//
// pin, unpin, dirty and release requests on a valid index pass through decide,
// modify and put; fresh grants, all-pinned, bad index and unknown actions pass
// through decide and put; a request that must replace a frame walks the clock
// hand over the table entries one at a time (up to about two passes over the
// frames handed out), limited by the single read port of the frame table
// reset is synchronous and active low; the table itself is never cleared,
// only frames already handed out are ever read
// the next request is taken while a result still waits on m_tready; a
// finished result waits in its state until the output register is free
module clock_frame_replacement_unit import cfru_pkg::*; #(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int SLOT_BITS = SLOT_BITS_DEF,
    localparam int IN_W  = ((IDX_W + PAGE_BITS + 2 * SLOT_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((IDX_W + PAGE_BITS + SLOT_BITS + 3 + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,   // frame_limit
    // request stream
    input  logic               s_tvalid,
    output logic               s_tready,
    // frame_index, owner_page, incoming_slot, spare_slot, zero pad
    input  logic [IN_W-1:0]    s_tdata,
    input  logic [ACT_W-1:0]   s_tuser,         // action
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    // granted_frame, evicted, victim_page, write_out, victim_slot,
    // spare_taken, zero pad
    output logic [OUT_W-1:0]   m_tdata,
    output logic [STAT_W-1:0]  m_tuser          // status
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: accept, decide, walk or modify, hand result over
    cfru_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .i_m_ready (m_tready),
        .i_stat    (w_stat),
        .o_s_ready (s_tready),
        .o_m_valid (m_tvalid),
        .o_cmd     (w_cmd)
    );

    // frame table, clock hand, counters and result registers
    cfru_dp #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .SLOT_BITS (SLOT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_act         (s_tuser),
        .i_data        (s_tdata),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_data        (m_tdata),
        .o_status      (m_tuser)
    );

endmodule
